// ===== sv/lru_key_table_unit_assert.svh =====
// assertion macros shared by the lru key table checker
`ifndef LRU_KEY_TABLE_UNIT_ASSERT_SVH
`define LRU_KEY_TABLE_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define LKT_ASSERT_IMPLIES(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("lkt assertion failed");

// next-cycle implication, disabled during reset
`define LKT_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("lkt assertion failed");

`endif

// ===== sv/lkt_pkg.sv =====
// shared types and constants for the lru key table
`timescale 1ns / 1ps

package lkt_pkg;

    // fixed widths of the request and result fields
    localparam int FIELD_KEY_W = 64;
    localparam int CAP_W       = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    // broadcast command to every entry
    typedef struct packed {
        logic touch;     // hit: move matching entry to most recent
        logic insert;    // insert miss: add key as most recent
        logic evict_do;  // insert miss also drops the oldest entry
    } entry_cmd_t;

    // per-entry selection from the top level
    typedef struct packed {
        logic found;
        logic evict;
        logic slot;
    } entry_sel_t;

    // per-entry status back to the top level
    typedef struct packed {
        logic valid;
        logic match;
        logic oldest;
    } entry_stat_t;

endpackage

// ===== sv/lkt_entry.sv =====
// one table entry: key, valid bit, recency rank and their update
`timescale 1ns / 1ps

module lkt_entry #(
    parameter int KEY_BITS = 64,
    parameter int RANK_W   = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  lkt_pkg::entry_cmd_t cmd,
    input  lkt_pkg::entry_sel_t sel,
    input  logic [KEY_BITS-1:0] key,
    input  logic [RANK_W-1:0]   touch_rank,
    input  logic [RANK_W-1:0]   evict_rank,
    output lkt_pkg::entry_stat_t stat,
    output logic [KEY_BITS-1:0] stored_key,
    output logic [RANK_W-1:0]   stored_rank
);

    logic                valid_reg;
    logic                valid_next;
    logic [RANK_W-1:0]   rank_reg;
    logic [RANK_W-1:0]   rank_next;
    logic [KEY_BITS-1:0] key_reg;
    logic                key_load;

    // status toward the top level
    assign stat.valid  = valid_reg;
    assign stat.match  = valid_reg && (key_reg == key);
    assign stat.oldest = valid_reg && (rank_reg == evict_rank);
    assign stored_key  = key_reg;
    assign stored_rank = rank_reg;

    // next valid and rank
    always_comb
    begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        key_load   = 1'b0;
        if (cmd.touch)
        begin
            if (sel.found)
            begin
                rank_next = '0;
            end
            else if (valid_reg && (rank_reg < touch_rank))
            begin
                rank_next = rank_reg + RANK_W'(1);
            end
        end
        else if (cmd.insert)
        begin
            if (sel.slot)
            begin
                valid_next = 1'b1;
                rank_next  = '0;
                key_load   = 1'b1;
            end
            else if (sel.evict && cmd.evict_do)
            begin
                valid_next = 1'b0;
                rank_next  = '0;
            end
            else if (valid_reg)
            begin
                rank_next = rank_reg + RANK_W'(1);
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
        end
    end

    // stored key, no reset
    always_ff @(posedge clk)
    begin
        if (key_load)
        begin
            key_reg <= key;
        end
    end

endmodule

// ===== sv/lru_key_table_unit.sv =====
// top level of the lru key table: request register, entry row, result register
`timescale 1ns / 1ps

// Fully associative LRU table of ENTRIES keys. A request is registered, then every entry
// compares its key in parallel and updates its recency rank once the result register is
// free or being read, and the result lands in an output register. One request is taken
// every cycle while the result side keeps up. The compare across all entries plus the
// rank update sets that rate. Reset clears all valid bits at once, so no clearing pass is
// needed. Capacity writes only ever raise the limit.
module lru_key_table_unit #(
    parameter int ENTRIES  = 16,
    parameter int KEY_BITS = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            func,
    input  logic [lkt_pkg::FIELD_KEY_W-1:0] key,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            hit,
    output logic                            evicted_valid,
    output logic [lkt_pkg::FIELD_KEY_W-1:0] evicted_key,
    output logic                            table_empty,
    input  logic                            cfg_wr_en,
    input  logic [lkt_pkg::CAP_W-1:0]       cfg_wr_data
);

    localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int HELD_W = $clog2(ENTRIES + 1);
    localparam int CMP_W  = (HELD_W > lkt_pkg::CAP_W) ? HELD_W : lkt_pkg::CAP_W;

    // request register
    logic                in_valid_reg;
    logic                func_reg;
    logic [KEY_BITS-1:0] key_reg;

    // result register
    logic                            out_valid_reg;
    logic                            hit_reg;
    logic                            ev_valid_reg;
    logic [lkt_pkg::FIELD_KEY_W-1:0] ev_key_reg;
    logic                            empty_reg;

    // table state
    logic [HELD_W-1:0]         held_reg;
    logic [HELD_W-1:0]         held_next;
    logic [lkt_pkg::CAP_W-1:0] cap_reg;

    // entry row
    lkt_pkg::entry_cmd_t  cmd;
    lkt_pkg::entry_sel_t  sel   [ENTRIES];
    lkt_pkg::entry_stat_t stat  [ENTRIES];
    logic [KEY_BITS-1:0]  skey  [ENTRIES];
    logic [RANK_W-1:0]    srank [ENTRIES];

    logic                advance;
    logic                hit_any;
    logic                full;
    logic                evict_do;
    logic [HELD_W-1:0]   held_m1;
    logic [RANK_W-1:0]   evict_rank;
    logic [RANK_W-1:0]   touch_rank;
    logic [KEY_BITS-1:0] evict_key_sel;
    logic [CMP_W-1:0]    held_ext;
    logic [CMP_W-1:0]    cap_ext;
    logic [CMP_W-1:0]    eff_cap;

    // handshake
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;

    // capacity limit and oldest rank
    assign held_ext   = CMP_W'(held_reg);
    assign cap_ext    = CMP_W'(cap_reg);
    assign eff_cap    = (cap_ext < CMP_W'(ENTRIES)) ? cap_ext : CMP_W'(ENTRIES);
    assign full       = (held_ext >= eff_cap) && (held_reg != '0);
    assign held_m1    = held_reg - HELD_W'(1);
    assign evict_rank = held_m1[RANK_W-1:0];

    // reductions over the entry row
    always_comb
    begin
        hit_any       = 1'b0;
        touch_rank    = '0;
        evict_key_sel = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            hit_any       = hit_any | stat[i].match;
            touch_rank    = touch_rank | (stat[i].match ? srank[i] : '0);
            evict_key_sel = evict_key_sel | (stat[i].oldest ? skey[i] : '0);
        end
    end

    assign evict_do = full && !hit_any && (func_reg == lkt_pkg::OP_INSERT);

    // command broadcast
    assign cmd.touch    = advance && hit_any;
    assign cmd.insert   = advance && !hit_any && (func_reg == lkt_pkg::OP_INSERT);
    assign cmd.evict_do = evict_do;

    // per-entry select, first free slot after eviction
    always_comb
    begin
        logic taken;
        logic free;
        taken = 1'b0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            free         = !stat[i].valid || (evict_do && stat[i].oldest);
            sel[i].found = stat[i].match;
            sel[i].evict = stat[i].oldest;
            sel[i].slot  = free && !taken;
            taken        = taken | free;
        end
    end

    // entry cells
    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_entry
        lkt_entry #(
            .KEY_BITS (KEY_BITS),
            .RANK_W   (RANK_W)
        ) u_entry (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .sel         (sel[g]),
            .key         (key_reg),
            .touch_rank  (touch_rank),
            .evict_rank  (evict_rank),
            .stat        (stat[g]),
            .stored_key  (skey[g]),
            .stored_rank (srank[g])
        );
    end

    // held count update
    always_comb
    begin
        held_next = held_reg;
        if (cmd.insert)
        begin
            held_next = held_reg - HELD_W'(evict_do) + HELD_W'(1);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            held_reg      <= '0;
            cap_reg       <= lkt_pkg::CAP_RESET;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            held_reg <= held_next;
            if (cfg_wr_en && (cfg_wr_data > cap_reg))
            begin
                cap_reg <= cfg_wr_data;
            end
        end
    end

    // request payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            func_reg <= func;
            key_reg  <= key[KEY_BITS-1:0];
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            hit_reg      <= hit_any;
            ev_valid_reg <= cmd.insert && evict_do;
            ev_key_reg   <= (cmd.insert && evict_do) ?
                            lkt_pkg::FIELD_KEY_W'(evict_key_sel) : '0;
            empty_reg    <= (held_next == '0);
        end
    end

    assign hit           = hit_reg;
    assign evicted_valid = ev_valid_reg;
    assign evicted_key   = ev_key_reg;
    assign table_empty   = empty_reg;

endmodule

// ===== sv/lkt_checker.sv =====
// port-level checker for the lru key table and its bind
`timescale 1ns / 1ps
`include "lru_key_table_unit_assert.svh"

module lkt_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic                            hit,
    input logic                            evicted_valid,
    input logic [lkt_pkg::FIELD_KEY_W-1:0] evicted_key,
    input logic                            table_empty
);

    // stalled result holds
    `LKT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(hit) && $stable(evicted_valid) && $stable(evicted_key))

    // eviction only on an insert miss
    `LKT_ASSERT_IMPLIES(a_evict_no_hit, clk, rst_n, out_valid && evicted_valid, !hit && !table_empty)

    // no eviction reports a zero key
    `LKT_ASSERT_IMPLIES(a_evict_key_zero, clk, rst_n, out_valid && !evicted_valid, evicted_key == '0)

    // a hit leaves at least one key
    `LKT_ASSERT_IMPLIES(a_hit_not_empty, clk, rst_n, out_valid && hit, !table_empty)

endmodule

bind lru_key_table_unit lkt_checker u_lkt_checker (.*);
